/* design/csvt_pkg.sv */
// csvt_pkg: shared types and constants for the CSV stream tokenizer
// holds result kinds, input modes, quote states, character codes and the result record
// no dependencies
`default_nettype none

package csvt_pkg;

    // default column limit, used as the parameter default of the top level and the tokenizer
    localparam int MAX_COLUMNS_DEF = 256;

    // result kinds
    localparam logic [1:0] KIND_CHAR    = 2'd0;
    localparam logic [1:0] KIND_FEND    = 2'd1;
    localparam logic [1:0] KIND_ROW     = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    // input modes
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // quote states
    localparam logic [1:0] QM_OUT  = 2'd0;
    localparam logic [1:0] QM_IN   = 2'd1;
    localparam logic [1:0] QM_PEND = 2'd2;

    // special characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // one result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_out;
        logic [8:0] column;
        logic [8:0] widest;
        logic       last_of_run;
    } res_t;

endpackage

`default_nettype wire

/* design/csvt_tokenize.sv */
// csvt_tokenize: per-byte decision logic of the CSV tokenizer
// computes next tokenizer state and up to two result items for one input item
// depends on csvt_pkg
`default_nettype none

module csvt_tokenize
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int CNT_W       = $clog2(MAX_COLUMNS + 1)
) (
    input  wire logic             mode,
    input  wire logic [7:0]       text_byte,
    input  wire logic [1:0]       qm,
    input  wire logic             fne,
    input  wire logic [CNT_W-1:0] fir,
    input  wire logic [CNT_W-1:0] wr,
    input  wire logic             held,
    output logic      [1:0]       qm_next,
    output logic                  fne_next,
    output logic      [CNT_W-1:0] fir_next,
    output logic      [CNT_W-1:0] wr_next,
    output logic                  held_next,
    output res_t                  res0,
    output res_t                  res1,
    output logic      [1:0]       n_res
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_COLUMNS);

    logic             outside;
    logic             act_char;
    logic             act_fend;
    logic             act_lf;
    logic             do_rel;
    logic             blank;
    logic             row_end;
    logic             flush;
    logic [CNT_W-1:0] fir_sat;
    logic [CNT_W-1:0] wr_rel;
    logic [CNT_W-1:0] wr_row;
    logic             a_v;
    logic             b_v;
    res_t             a_res;
    res_t             b_res;

    // saturating field count after the current field
    assign fir_sat = (fir < MAX_CNT) ? fir + CNT_W'(1) : MAX_CNT;

    // classify the byte by quote state
    always_comb begin
        outside  = 1'b0;
        act_char = 1'b0;
        act_fend = 1'b0;
        act_lf   = 1'b0;
        qm_next  = qm;
        unique case (qm)
            QM_IN: begin
                if (text_byte == CH_QUOTE) begin
                    qm_next = QM_PEND;
                end else begin
                    act_char = 1'b1;
                end
            end
            QM_PEND: begin
                if (text_byte == CH_QUOTE) begin
                    qm_next  = QM_IN;
                    act_char = 1'b1;
                end else begin
                    qm_next = QM_OUT;
                    outside = 1'b1;
                end
            end
            default: begin
                qm_next = QM_OUT;
                outside = 1'b1;
            end
        endcase
        if (outside) begin
            if (text_byte == CH_QUOTE) begin
                qm_next = QM_IN;
            end else if (text_byte == CH_COMMA) begin
                act_fend = 1'b1;
            end else if (text_byte == CH_CR) begin
                act_char = 1'b0;
            end else if (text_byte == CH_LF) begin
                act_lf = 1'b1;
            end else begin
                act_char = 1'b1;
            end
        end
        if (mode == MODE_END) begin
            qm_next  = QM_OUT;
            act_char = 1'b0;
            act_fend = 1'b0;
            act_lf   = 1'b0;
        end
    end

    // release of a held blank row and row-end decisions
    assign do_rel  = held && (act_char || act_fend || act_lf);
    assign blank   = act_lf && (fir == '0) && !fne;
    assign row_end = act_lf && !blank;
    assign flush   = fne || (fir != '0);

    // widest row tracking
    assign wr_rel = (do_rel && (wr == '0)) ? CNT_W'(1) : wr;
    assign wr_row = ((row_end || (mode == MODE_END && flush)) && (fir_sat > wr_rel))
                    ? fir_sat : wr_rel;

    // next state
    always_comb begin
        fne_next  = fne;
        fir_next  = fir;
        held_next = held;
        wr_next   = wr_row;
        if (mode == MODE_END) begin
            fne_next  = 1'b0;
            fir_next  = '0;
            held_next = 1'b0;
            wr_next   = '0;
        end else begin
            if (act_char) begin
                fne_next = 1'b1;
            end
            if (act_fend) begin
                fne_next = 1'b0;
                fir_next = fir_sat;
            end
            if (row_end) begin
                fne_next = 1'b0;
                fir_next = '0;
            end
            if (do_rel) begin
                held_next = 1'b0;
            end
            if (blank) begin
                held_next = 1'b1;
            end
        end
    end

    // candidate results: a comes first, b is the main result
    always_comb begin
        a_v   = 1'b0;
        b_v   = 1'b0;
        a_res = '0;
        b_res = '0;
        if (mode == MODE_END) begin
            a_v          = flush;
            a_res.kind   = KIND_ROW;
            a_res.column = 9'(fir);
            b_v          = 1'b1;
            b_res.kind   = KIND_SUMMARY;
            b_res.widest = 9'(wr_row);
        end else begin
            a_v          = do_rel;
            a_res.kind   = KIND_ROW;
            b_v          = act_char || act_fend || row_end;
            b_res.column = 9'(fir);
            if (act_char) begin
                b_res.kind     = KIND_CHAR;
                b_res.char_out = text_byte;
            end else if (act_fend) begin
                b_res.kind = KIND_FEND;
            end else begin
                b_res.kind = KIND_ROW;
            end
        end
    end

    // pack results in order and mark the last one
    always_comb begin
        n_res = {1'b0, a_v} + {1'b0, b_v};
        res0  = a_v ? a_res : b_res;
        res1  = b_res;
        res0.last_of_run = (n_res == 2'd1);
        res1.last_of_run = 1'b1;
    end

endmodule

`default_nettype wire

/* design/csvt_out_buf.sv */
// csvt_out_buf: two-entry result register feeding the master stream
// takes up to two results at once and presents them one per transfer
// depends on csvt_pkg
`default_nettype none

module csvt_out_buf
    import csvt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire logic [1:0] n_res,
    input  wire res_t       res0,
    input  wire res_t       res1,
    input  wire logic       m_ready,
    output logic            m_valid,
    output res_t            m_res,
    output logic            can_load
);

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    res_t       slot0_reg;
    res_t       slot0_next;
    res_t       slot1_reg;
    res_t       slot1_next;
    logic       pop;

    assign m_valid  = (cnt_reg != 2'd0);
    assign m_res    = slot0_reg;
    assign pop      = m_valid && m_ready;
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);

    // load a new pair or shift after a transfer
    always_comb begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load && n_res != 2'd0) begin
            cnt_next   = n_res;
            slot0_next = res0;
            slot1_next = res1;
        end else if (pop) begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    // count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire

/* design/csv_stream_tokenizer.sv */
// csv_stream_tokenizer: top level of the streaming CSV tokenizer
// input register, tokenizer state and output buffer
// depends on csvt_pkg, csvt_tokenize, csvt_out_buf
//
// Usage: the slave stream carries one CSV byte per transfer in s_tdata, with
// s_tuser high marking an end-of-input item (byte ignored). The master stream
// returns field characters, field ends, row ends and a final summary; m_tuser
// holds the kind, m_tlast marks the last result caused by one input item.
// A result passes the input register, then the result register, before it is
// offered on the master side. Throughput: one byte per cycle while the
// receiver keeps m_tready high; an item that causes two results (a released
// blank row before the next result, or a row flush plus summary at end of
// input) holds the master side for both transfers, since the two-entry
// output buffer has a single result port.
// Items with no result (unquoted CR, opening or closing quote) use no output slot.
// Reset (aresetn low at a clock edge) clears the quote state, counters, the
// held blank row and both buffers. When the receiver stalls, results wait in
// the output buffer and s_tready drops once the input register is also full;
// nothing is lost or repeated. After an end-of-input item the tokenizer state
// is back in its reset state.
`default_nettype none

module csv_stream_tokenizer
    import csvt_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // text_byte[7:0]
    input  wire logic        s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // char_out[7:0], column[16:8], widest[25:17], zeros
    output logic      [1:0]  m_tuser,   // kind[1:0]
    output logic             m_tlast
);

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic             in_mode_reg;
    logic [7:0]       in_byte_reg;
    logic [1:0]       qm_reg;
    logic [1:0]       qm_next;
    logic             fne_reg;
    logic             fne_next;
    logic [CNT_W-1:0] fir_reg;
    logic [CNT_W-1:0] fir_next;
    logic [CNT_W-1:0] wr_reg;
    logic [CNT_W-1:0] wr_next;
    logic             held_reg;
    logic             held_next;
    res_t             res0;
    res_t             res1;
    logic [1:0]       n_res;
    logic             can_load;
    logic             consume;
    logic             s_xfer;
    res_t             m_res;

    // input register handshake
    assign consume  = in_valid_reg && (can_load || n_res == 2'd0);
    assign s_tready = !in_valid_reg || consume;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (consume) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // per-byte decision logic
    csvt_tokenize #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .CNT_W       (CNT_W)
    ) u_tokenize (
        .mode      (in_mode_reg),
        .text_byte (in_byte_reg),
        .qm        (qm_reg),
        .fne       (fne_reg),
        .fir       (fir_reg),
        .wr        (wr_reg),
        .held      (held_reg),
        .qm_next   (qm_next),
        .fne_next  (fne_next),
        .fir_next  (fir_next),
        .wr_next   (wr_next),
        .held_next (held_next),
        .res0      (res0),
        .res1      (res1),
        .n_res     (n_res)
    );

    // tokenizer state, updated when an item is consumed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qm_reg   <= QM_OUT;
            fne_reg  <= 1'b0;
            fir_reg  <= '0;
            wr_reg   <= '0;
            held_reg <= 1'b0;
        end else if (consume) begin
            qm_reg   <= qm_next;
            fne_reg  <= fne_next;
            fir_reg  <= fir_next;
            wr_reg   <= wr_next;
            held_reg <= held_next;
        end
    end

    // result buffer
    csvt_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (consume),
        .n_res    (n_res),
        .res0     (res0),
        .res1     (res1),
        .m_ready  (m_tready),
        .m_valid  (m_tvalid),
        .m_res    (m_res),
        .can_load (can_load)
    );

    // master stream packing
    assign m_tdata = {6'b0, m_res.widest, m_res.column, m_res.char_out};
    assign m_tuser = m_res.kind;
    assign m_tlast = m_res.last_of_run;

    // the field counter stays within its limit
    a_fir_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fir_reg <= CNT_W'(MAX_COLUMNS))
        else $error("field count above limit");

    // a held blank row implies an empty row in progress
    a_held_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg |-> (fir_reg == '0 && !fne_reg))
        else $error("blank row held with row content");

    // end of input returns the tokenizer to its reset state
    a_end_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && in_mode_reg == MODE_END) |=>
            (qm_reg == QM_OUT && fir_reg == '0 && wr_reg == '0 && !held_reg && !fne_reg))
        else $error("state not cleared after end of input");

    // a summary is always the last result of its item
    a_summary_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_SUMMARY) |-> m_tlast)
        else $error("summary not marked last");

    // only a summary carries a widest value
    a_widest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != KIND_SUMMARY) |-> (m_tdata[25:17] == 9'd0))
        else $error("widest set on a non-summary result");

endmodule

`default_nettype wire
